// File: sv/b64se_pkg.sv
// Shared types, constants and the symbol lookup for the base64 stream encoder.
package b64se_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        CMD_GROUP,
        CMD_FINAL,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [1:0]  nbytes;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [15:0] total_length;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        begin
            w = {2'b00, v};
            if (v < 6'd26) begin
                return 8'h41 + w;
            end else if (v < 6'd52) begin
                return 8'h61 + (w - 8'd26);
            end else if (v < 6'd62) begin
                return 8'h30 + (w - 8'd52);
            end else if (v == 6'd62) begin
                return 8'h2B;
            end else begin
                return 8'h2F;
            end
        end
    endfunction

endpackage

// File: sv/b64se_front.sv
// Front end: collects bytes into groups, checks capacity, issues group, final and error commands.
module b64se_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_last_byte,
    input  logic [15:0]          capacity,
    input  b64se_pkg::queue_status_t q_status,
    output logic                 push,
    output b64se_pkg::cmd_t      push_cmd
);

    logic [1:0]  group_phase_reg, group_phase_next;
    logic [15:0] held_bytes_reg, held_bytes_next;
    logic [15:0] chars_written_reg, chars_written_next;
    logic        overflowed_reg, overflowed_next;

    logic        accept;
    logic [16:0] sum;
    logic        fits_mid;
    logic        fits_end;
    logic [7:0]  b0, b1, b2;

    assign s_ready  = !q_status.full;
    assign accept   = s_valid && s_ready;
    assign sum      = {1'b0, chars_written_reg} + 17'd4;
    assign fits_mid = sum <= {1'b0, capacity};
    assign fits_end = sum < {1'b0, capacity};

    always_comb begin
        b0 = held_bytes_reg[15:8];
        b1 = held_bytes_reg[7:0];
        b2 = 8'h00;
        case (group_phase_reg)
            2'd1: begin
                b1 = s_data_byte;
            end
            2'd2: begin
                b2 = s_data_byte;
            end
            default: begin
                b0 = s_data_byte;
                b1 = 8'h00;
            end
        endcase
    end

    always_comb begin
        group_phase_next   = group_phase_reg;
        held_bytes_next    = held_bytes_reg;
        chars_written_next = chars_written_reg;
        overflowed_next    = overflowed_reg;
        push               = 1'b0;
        push_cmd.kind         = b64se_pkg::CMD_GROUP;
        push_cmd.nbytes       = (group_phase_reg == 2'd3) ? 2'd1 : group_phase_reg + 2'd1;
        push_cmd.b0           = b0;
        push_cmd.b1           = b1;
        push_cmd.b2           = b2;
        push_cmd.total_length = 16'd0;
        if (accept) begin
            if (!s_last_byte) begin
                if (group_phase_reg == 2'd1) begin
                    group_phase_next = 2'd2;
                    held_bytes_next  = {held_bytes_reg[15:8], s_data_byte};
                end else if (group_phase_reg != 2'd2) begin
                    group_phase_next = 2'd1;
                    held_bytes_next  = {s_data_byte, 8'h00};
                end else begin
                    group_phase_next = 2'd0;
                    held_bytes_next  = 16'd0;
                    if (!overflowed_reg) begin
                        if (fits_mid) begin
                            push               = 1'b1;
                            chars_written_next = sum[15:0];
                        end else begin
                            overflowed_next = 1'b1;
                        end
                    end
                end
            end else begin
                push = 1'b1;
                if (overflowed_reg || !fits_end) begin
                    push_cmd.kind         = b64se_pkg::CMD_ERROR;
                    push_cmd.total_length = chars_written_reg;
                end else begin
                    push_cmd.kind         = b64se_pkg::CMD_FINAL;
                    push_cmd.total_length = sum[15:0];
                end
                group_phase_next   = 2'd0;
                held_bytes_next    = 16'd0;
                chars_written_next = 16'd0;
                overflowed_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_phase_reg   <= 2'd0;
            held_bytes_reg    <= 16'd0;
            chars_written_reg <= 16'd0;
            overflowed_reg    <= 1'b0;
        end else begin
            group_phase_reg   <= group_phase_next;
            held_bytes_reg    <= held_bytes_next;
            chars_written_reg <= chars_written_next;
            overflowed_reg    <= overflowed_next;
        end
    end

endmodule

// File: sv/b64se_queue.sv
// Small command queue between the front end and the character emitter.
module b64se_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  b64se_pkg::cmd_t          push_cmd,
    input  logic                     pop,
    output b64se_pkg::cmd_t          head_cmd,
    output b64se_pkg::queue_status_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    b64se_pkg::cmd_t entries_reg [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/b64se_back.sv
// Back end: turns queued commands into characters, one per cycle while m_ready allows.
module b64se_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  b64se_pkg::cmd_t          head_cmd,
    input  b64se_pkg::queue_status_t q_status,
    output logic                     pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_out_char,
    output logic                     m_end_mark,
    output logic                     m_overflow,
    output logic [15:0]              m_total_length
);

    logic [1:0]  idx_reg, idx_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        end_mark_reg, end_mark_next;
    logic        overflow_reg, overflow_next;
    logic [15:0] total_length_reg, total_length_next;

    logic        load;
    logic [7:0]  chars [4];

    always_comb begin
        chars[0] = b64se_pkg::b64_char(head_cmd.b0[7:2]);
        chars[1] = b64se_pkg::b64_char({head_cmd.b0[1:0], head_cmd.b1[7:4]});
        chars[2] = (head_cmd.nbytes >= 2'd2)
                   ? b64se_pkg::b64_char({head_cmd.b1[3:0], head_cmd.b2[7:6]})
                   : b64se_pkg::PAD_CHAR;
        chars[3] = (head_cmd.nbytes == 2'd3)
                   ? b64se_pkg::b64_char(head_cmd.b2[5:0])
                   : b64se_pkg::PAD_CHAR;
    end

    always_comb begin
        load              = !m_valid_reg || m_ready;
        pop               = 1'b0;
        idx_next          = idx_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        out_char_next     = out_char_reg;
        end_mark_next     = end_mark_reg;
        overflow_next     = overflow_reg;
        total_length_next = total_length_reg;
        if (load && !q_status.empty) begin
            m_valid_next = 1'b1;
            case (head_cmd.kind)
                b64se_pkg::CMD_ERROR: begin
                    out_char_next     = 8'h00;
                    end_mark_next     = 1'b1;
                    overflow_next     = 1'b1;
                    total_length_next = head_cmd.total_length;
                    pop               = 1'b1;
                    idx_next          = 2'd0;
                end
                b64se_pkg::CMD_FINAL, b64se_pkg::CMD_GROUP: begin
                    out_char_next     = chars[idx_reg];
                    overflow_next     = 1'b0;
                    end_mark_next     = (head_cmd.kind == b64se_pkg::CMD_FINAL)
                                        && (idx_reg == 2'd3);
                    total_length_next = end_mark_next ? head_cmd.total_length : 16'd0;
                    pop               = (idx_reg == 2'd3);
                    idx_next          = idx_reg + 2'd1;
                end
                default: begin
                    m_valid_next = 1'b0;
                    pop          = 1'b1;
                    idx_next     = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_char_reg     <= out_char_next;
        end_mark_reg     <= end_mark_next;
        overflow_reg     <= overflow_next;
        total_length_reg <= total_length_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_char     = out_char_reg;
    assign m_end_mark     = end_mark_reg;
    assign m_overflow     = overflow_reg;
    assign m_total_length = total_length_reg;

endmodule

// File: sv/base64_stream_encoder.sv
// Top level of the base64 stream encoder: register port, front end, queue, back end.
//
//   channel   direction  handshake          payload
//   s_*       in         s_valid/s_ready    s_data_byte, s_last_byte
//   m_*       out        m_valid/m_ready    m_out_char, m_end_mark, m_overflow,
//                                           m_total_length
//   apb       in         psel/penable       paddr, pwdata, prdata (capacity)
//
// Bytes are taken one per cycle while the command queue has room.
// The emitter sends one character per cycle while m_ready allows: four per group, one per error.
// A steady stream is therefore limited by the emitter rather than by the byte port.
// The first character passes through the queue entry and the output register after the byte that completes its group.
// Reset is synchronous; capacity returns to 65535 and all message state clears.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_end_mark,
    output logic        m_overflow,
    output logic [15:0] m_total_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] capacity_reg, capacity_next;

    logic                     push;
    logic                     pop;
    b64se_pkg::cmd_t          push_cmd;
    b64se_pkg::cmd_t          head_cmd;
    b64se_pkg::queue_status_t q_status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, capacity_reg} : 32'd0;

    always_comb begin
        capacity_next = capacity_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            capacity_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= 16'hFFFF;
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    b64se_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .capacity    (capacity_reg),
        .q_status    (q_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    b64se_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    b64se_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_cmd       (head_cmd),
        .q_status       (q_status),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_char     (m_out_char),
        .m_end_mark     (m_end_mark),
        .m_overflow     (m_overflow),
        .m_total_length (m_total_length)
    );

`ifndef SYNTHESIS
    a_ovf_ends_message: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overflow) |-> (m_end_mark && (m_out_char == 8'h00)))
        else $error("overflow request not a closing request");

    a_len_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_end_mark) |-> (m_total_length == 16'd0))
        else $error("length on a request that does not close the message");

    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty) && (s_ready == !q_status.full))
        else $error("queue status inconsistent");

    a_pop_with_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");
`endif

endmodule
